@@ rtl/spq_pkg.sv @@
// Shared constants and types for the stable priority queue.
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int PRIO_WIDTH_DEF = 8;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_POP   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   // Shift command broadcast to every cell.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_ctrl_type;

   // What a cell reports about itself for the incoming priority.
   typedef struct packed {
      logic occupied;
      logic ge;
   } cell_stat_type;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// One storage cell of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell #(
   parameter int INDEX      = 0,
   parameter int CNT_W      = 5,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 8
) (
   input  wire                        clock,
   input  spq_pkg::cell_ctrl_type     ctrl,
   input  wire  [CNT_W-1:0]           count,
   input  wire  [DATA_WIDTH-1:0]      new_value,
   input  wire  [PRIO_WIDTH-1:0]      new_prio,
   input  wire                        left_ge,
   input  wire  [DATA_WIDTH-1:0]      left_value,
   input  wire  [PRIO_WIDTH-1:0]      left_prio,
   input  wire  [DATA_WIDTH-1:0]      right_value,
   input  wire  [PRIO_WIDTH-1:0]      right_prio,
   output spq_pkg::cell_stat_type     stat,
   output logic [DATA_WIDTH-1:0]      value,
   output logic [PRIO_WIDTH-1:0]      prio,
   output logic [DATA_WIDTH-1:0]      value_next
);
   import spq_pkg::*;

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic [PRIO_WIDTH-1:0] prio_ff;
   logic [PRIO_WIDTH-1:0] prio_in;

   assign stat.occupied = (CNT_W'(INDEX) < count);
   assign stat.ge       = stat.occupied && (prio_ff >= new_prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.push) begin
         if (!stat.ge) begin
            // first cell below the new priority takes the item, the rest shift back
            if (left_ge || (INDEX == 0)) begin
               value_in = new_value;
               prio_in  = new_prio;
            end else begin
               value_in = left_value;
               prio_in  = left_prio;
            end
         end
      end else if (ctrl.pop) begin
         value_in = right_value;
         prio_in  = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value      = value_ff;
   assign prio       = prio_ff;
   assign value_next = value_in;

endmodule

`default_nettype wire

@@ rtl/stable_priority_queue.sv @@
// A response is registered and appears in the cycle after its request is accepted.
// Throughput: one push, pop or clear per cycle while rsp_ready stays high; every cell
// compares against the incoming priority in parallel and shifts in the same cycle.
// Reset clears the entry count and the response valid; cell contents stay undefined
// until written and are never read while unoccupied.
`default_nettype none

module stable_priority_queue #(
   parameter int DEPTH      = spq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF,
   parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire         [spq_pkg::OP_W-1:0]      req_operation,
   input  wire  signed [spq_pkg::VALUE_W-1:0]   req_value,
   input  wire         [spq_pkg::PRIO_W-1:0]    req_priority_req,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic        [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0]   rsp_popped_value,
   output logic signed [spq_pkg::VALUE_W-1:0]   rsp_head_value,
   output logic signed [spq_pkg::VALUE_W-1:0]   rsp_tail_value,
   output logic        [spq_pkg::COUNT_W-1:0]   rsp_count
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  accept;
   logic [DATA_WIDTH-1:0] new_value;
   logic [PRIO_WIDTH-1:0] new_prio;
   logic                  full;
   logic                  empty;
   logic                  any_lt;
   cell_ctrl_type         ctrl;
   logic [STATUS_W-1:0]   status;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [DATA_WIDTH-1:0] tail_ff;
   logic [DATA_WIDTH-1:0] tail_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [VALUE_W-1:0]    popped_ff;
   logic [VALUE_W-1:0]    popped_in;
   logic [VALUE_W-1:0]    head_ff;
   logic [VALUE_W-1:0]    head_in;
   logic [VALUE_W-1:0]    tail_out_ff;
   logic [VALUE_W-1:0]    tail_out_in;
   // count reported with the response, captured at acceptance
   logic [CNT_W-1:0]      count_rsp_ff;

   cell_stat_type         cell_stat  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic [PRIO_WIDTH-1:0] cell_prio  [DEPTH];
   logic [DATA_WIDTH-1:0] cell_next  [DEPTH];
   logic [DEPTH-1:0]      lt_vec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign new_value = DATA_WIDTH'($unsigned(req_value));
   assign new_prio  = PRIO_WIDTH'(req_priority_req);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl     = '0;
      status   = STATUS_OK;
      count_in = count_ff;
      if (accept) begin
         unique case (req_operation)
            OP_PUSH: begin
               if (full) begin
                  status = STATUS_PUSH_FULL;
               end else begin
                  ctrl.push = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               if (empty) begin
                  status = STATUS_POP_EMPTY;
               end else begin
                  ctrl.pop = 1'b1;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                  left_ge;
         logic [DATA_WIDTH-1:0] left_value;
         logic [PRIO_WIDTH-1:0] left_prio;
         logic [DATA_WIDTH-1:0] right_value;
         logic [PRIO_WIDTH-1:0] right_prio;

         if (i == 0) begin : g_first
            assign left_ge    = 1'b0;
            assign left_value = new_value;
            assign left_prio  = new_prio;
         end else begin : g_inner_left
            assign left_ge    = cell_stat[i-1].ge;
            assign left_value = cell_value[i-1];
            assign left_prio  = cell_prio[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign right_value = cell_value[i];
            assign right_prio  = cell_prio[i];
         end else begin : g_inner_right
            assign right_value = cell_value[i+1];
            assign right_prio  = cell_prio[i+1];
         end

         spq_cell #(
            .INDEX      (i),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .new_value   (new_value),
            .new_prio    (new_prio),
            .left_ge     (left_ge),
            .left_value  (left_value),
            .left_prio   (left_prio),
            .right_value (right_value),
            .right_prio  (right_prio),
            .stat        (cell_stat[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i]),
            .value_next  (cell_next[i])
         );

         assign lt_vec[i] = cell_stat[i].occupied && !cell_stat[i].ge;
      end
   endgenerate

   assign any_lt = |lt_vec;

   // tail only changes when a push lands behind every stored entry
   always_comb begin
      tail_in = tail_ff;
      if (ctrl.push && !any_lt) begin
         tail_in = new_value;
      end
   end

   always_comb begin
      popped_in   = ctrl.pop ? VALUE_W'(cell_value[0]) : '0;
      head_in     = (count_in != '0) ? VALUE_W'(cell_next[0]) : '0;
      tail_out_in = (count_in != '0) ? VALUE_W'(tail_in) : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      if (accept) begin
         status_ff    <= status;
         popped_ff    <= popped_in;
         head_ff      <= head_in;
         tail_out_ff  <= tail_out_in;
         count_rsp_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = $signed(popped_ff);
   assign rsp_head_value   = $signed(head_ff);
   assign rsp_tail_value   = $signed(tail_out_ff);
   assign rsp_count        = COUNT_W'(count_rsp_ff);

endmodule

`default_nettype wire

@@ rtl/spq_checker.sv @@
// Port-level checks for the stable priority queue, bound to the top level.
`default_nettype none

module spq_checker #(
   parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire        [spq_pkg::STATUS_W-1:0]  rsp_status,
   input wire signed [spq_pkg::VALUE_W-1:0]   rsp_popped_value,
   input wire signed [spq_pkg::VALUE_W-1:0]   rsp_head_value,
   input wire signed [spq_pkg::VALUE_W-1:0]   rsp_tail_value,
   input wire        [spq_pkg::COUNT_W-1:0]   rsp_count
);
   import spq_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   // an empty queue shows no head or tail
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == '0) |-> (rsp_head_value == '0 && rsp_tail_value == '0))
      else $error("empty queue reports nonzero head or tail");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_POP_EMPTY)
         |-> (rsp_count == '0 && rsp_popped_value == '0))
      else $error("pop-empty error with entries present or a popped value");

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_PUSH_FULL) |-> (rsp_count == FULL_COUNT))
      else $error("push dropped while queue not full");

   a_single_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count == COUNT_W'(1)) |-> (rsp_head_value == rsp_tail_value))
      else $error("single entry with differing head and tail");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
         && $stable(rsp_head_value)))
      else $error("stalled response changed");

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_popped_value (rsp_popped_value),
   .rsp_head_value   (rsp_head_value),
   .rsp_tail_value   (rsp_tail_value),
   .rsp_count        (rsp_count)
);

`default_nettype wire
